/* hw/rtl/psvp_pkg.sv */
// shared types, register indexes and widths for the planar shadow vertex projector
`timescale 1ns / 1ps

package psvp_pkg;

  // configuration register indexes
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_GROUND_X      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_GROUND_Y      = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_GROUND_Z      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_LIGHT_X       = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_LIGHT_Y       = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_LIGHT_Z       = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_GROUND_OFFSET = 3'd6;
  localparam int CfgDataW = 32;

  // reset values: unit z normal and light, scaled light of 1.0 in Q8.24
  localparam logic signed [15:0] GROUND_Z_RST = 16'sd16384;
  localparam logic signed [15:0] LIGHT_Z_RST  = 16'sd16384;
  localparam logic signed [31:0] SCALED_Z_RST = 32'sd16777216;

  // derivation widths
  localparam int DotW = 34;  // light.ground in Q.28
  localparam int KW   = 34;  // 0.5 - d, positive when used
  localparam int LW   = 36;  // adjusted light in Q.28
  localparam int AccW = 54;  // adjusted light . ground before rounding
  localparam int DivW = 40;  // divisor d
  localparam int NumW = 61;  // dividend and quotient of the serial divider
  localparam int CntW = $clog2(NumW);
  localparam logic signed [DivW-1:0] HALF_Q28 = 40'sd134217728;

  // vertex datapath widths
  localparam int PrdW   = 48;  // pos * ground
  localparam int HSumW  = 50;  // h before rounding
  localparam int HW     = 36;  // h in Q.16
  localparam int SplitW = 17;  // low part of |h| for the split multiply
  localparam int HiW    = 32 + HW - SplitW;
  localparam int LoW    = 32 + SplitW;
  localparam int ResW   = 43;  // rounded correction magnitude
  localparam int CorrW  = 45;  // position minus correction before saturation

  typedef struct packed {
    logic signed [15:0] ground_x;
    logic signed [15:0] ground_y;
    logic signed [15:0] ground_z;
    logic signed [15:0] light_x;
    logic signed [15:0] light_y;
    logic signed [15:0] light_z;
    logic signed [31:0] ground_offset;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } svec_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               last_in;
  } vtx_in_t;

  typedef struct packed {
    logic signed [31:0] proj_x;
    logic signed [31:0] proj_y;
    logic signed [31:0] proj_z;
    logic               last_out;
  } vtx_out_t;

endpackage

/* hw/rtl/psvp_derive.sv */
// scaled light derivation: dot products, light adjustment and a serial divider
`timescale 1ns / 1ps

module psvp_derive (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  psvp_pkg::cfg_t  cfg_i,
  output logic            busy_o,
  output psvp_pkg::svec_t scaled_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DOT, ST_ADJ, ST_ACC, ST_FIX, ST_LOAD, ST_RUN, ST_STORE
  } state_e;

  state_e state_q;
  logic [1:0] idx_q;
  logic [psvp_pkg::CntW-1:0] cnt_q;
  logic adj_q;
  logic neg_q;
  logic signed [psvp_pkg::DivW-1:0] d_q;
  logic [psvp_pkg::DivW-1:0] div_d_q;
  logic signed [psvp_pkg::LW-1:0] l_q [3];
  logic signed [psvp_pkg::AccW-1:0] acc_q;
  logic [psvp_pkg::DivW-1:0] rem_q;
  logic [psvp_pkg::NumW-1:0] num_q;
  logic signed [31:0] scaled_q [3];

  logic signed [15:0] g_sel;
  logic signed [15:0] lt_sel;
  logic signed [psvp_pkg::LW-1:0] l_sel;
  logic signed [psvp_pkg::DotW-1:0] dot;
  logic signed [psvp_pkg::DivW-1:0] k_full;
  logic signed [psvp_pkg::KW-1:0] k;
  logic signed [49:0] kg;
  logic signed [49:0] kg_rnd_full;
  logic signed [psvp_pkg::LW-1:0] kg_rnd;
  logic signed [psvp_pkg::LW-1:0] lt_sh;
  logic signed [psvp_pkg::LW-1:0] l_adj;
  logic signed [51:0] acc_prod;
  logic signed [psvp_pkg::AccW-1:0] acc_rnd_full;
  logic signed [psvp_pkg::DivW-1:0] dn;
  logic [psvp_pkg::LW-1:0] l_mag;
  logic [psvp_pkg::NumW-1:0] num_init;
  logic [psvp_pkg::DivW:0] rem_s;
  logic [psvp_pkg::DivW:0] rem_sub;
  logic ge;
  logic big;
  logic [31:0] q_lo;
  logic signed [31:0] q_sat;

  // component select
  always_comb begin
    case (idx_q)
      2'd0: begin
        g_sel  = cfg_i.ground_x;
        lt_sel = cfg_i.light_x;
      end
      2'd1: begin
        g_sel  = cfg_i.ground_y;
        lt_sel = cfg_i.light_y;
      end
      default: begin
        g_sel  = cfg_i.ground_z;
        lt_sel = cfg_i.light_z;
      end
    endcase
  end
  assign l_sel = l_q[idx_q];

  // d = light . ground in Q.28
  assign dot = cfg_i.light_x * cfg_i.ground_x + cfg_i.light_y * cfg_i.ground_y
             + cfg_i.light_z * cfg_i.ground_z;

  // light + rnd14((0.5 - d) * ground)
  assign k_full      = psvp_pkg::HALF_Q28 - d_q;
  assign k           = k_full[psvp_pkg::KW-1:0];
  assign kg          = k * g_sel;
  assign kg_rnd_full = (kg + 50'sd8192) >>> 14;
  assign kg_rnd      = kg_rnd_full[psvp_pkg::LW-1:0];
  assign lt_sh       = {{(psvp_pkg::LW-30){lt_sel[15]}}, lt_sel, 14'd0};
  assign l_adj       = adj_q ? lt_sh + kg_rnd : lt_sh;

  // recomputed d
  assign acc_prod     = l_sel * g_sel;
  assign acc_rnd_full = (acc_q + 54'sd8192) >>> 14;

  // divisor choice, clamped to one lsb when not positive
  always_comb begin
    dn = adj_q ? acc_rnd_full[psvp_pkg::DivW-1:0] : d_q;
    if (dn[psvp_pkg::DivW-1] || dn == '0) begin
      dn = {{(psvp_pkg::DivW-1){1'b0}}, 1'b1};
    end
  end

  // dividend: |l| * 2^24 + d / 2
  assign l_mag    = l_sel[psvp_pkg::LW-1] ? ~l_sel + 1'b1 : l_sel;
  assign num_init = {{(psvp_pkg::NumW-psvp_pkg::LW-24){1'b0}}, l_mag, 24'd0}
                  + {{(psvp_pkg::NumW-psvp_pkg::DivW+1){1'b0}},
                     div_d_q[psvp_pkg::DivW-1:1]};

  // one restoring step per cycle
  assign rem_s   = {rem_q, num_q[psvp_pkg::NumW-1]};
  assign ge      = rem_s >= {1'b0, div_d_q};
  assign rem_sub = rem_s - {1'b0, div_d_q};

  // quotient saturation toward the light's sign
  assign big  = |num_q[psvp_pkg::NumW-1:31];
  assign q_lo = num_q[31:0];
  always_comb begin
    if (neg_q) begin
      q_sat = big ? 32'sh8000_0000 : ~q_lo + 1'b1;
    end else begin
      q_sat = big ? 32'sh7fff_ffff : q_lo;
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= 2'd0;
      cnt_q       <= '0;
      adj_q       <= 1'b0;
      neg_q       <= 1'b0;
      scaled_q[0] <= '0;
      scaled_q[1] <= '0;
      scaled_q[2] <= psvp_pkg::SCALED_Z_RST;
    end else if (start_i) begin
      state_q <= ST_DOT;
    end else begin
      case (state_q)
        ST_IDLE: begin
          state_q <= ST_IDLE;
        end
        ST_DOT: begin
          d_q     <= {{(psvp_pkg::DivW-psvp_pkg::DotW){dot[psvp_pkg::DotW-1]}}, dot};
          adj_q   <= dot < 34'sd134217728;
          idx_q   <= 2'd0;
          state_q <= ST_ADJ;
        end
        ST_ADJ: begin
          l_q[idx_q] <= l_adj;
          acc_q      <= '0;
          if (idx_q == 2'd2) begin
            idx_q   <= 2'd0;
            state_q <= ST_ACC;
          end else begin
            idx_q <= idx_q + 2'd1;
          end
        end
        ST_ACC: begin
          acc_q <= acc_q + acc_prod;
          if (idx_q == 2'd2) begin
            idx_q   <= 2'd0;
            state_q <= ST_FIX;
          end else begin
            idx_q <= idx_q + 2'd1;
          end
        end
        ST_FIX: begin
          div_d_q <= dn;
          state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          num_q   <= num_init;
          rem_q   <= '0;
          neg_q   <= l_sel[psvp_pkg::LW-1];
          cnt_q   <= '0;
          state_q <= ST_RUN;
        end
        ST_RUN: begin
          rem_q <= ge ? rem_sub[psvp_pkg::DivW-1:0] : rem_s[psvp_pkg::DivW-1:0];
          num_q <= {num_q[psvp_pkg::NumW-2:0], ge};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == psvp_pkg::CntW'(psvp_pkg::NumW - 1)) begin
            state_q <= ST_STORE;
          end
        end
        ST_STORE: begin
          scaled_q[idx_q] <= q_sat;
          if (idx_q == 2'd2) begin
            idx_q   <= 2'd0;
            state_q <= ST_IDLE;
          end else begin
            idx_q   <= idx_q + 2'd1;
            state_q <= ST_LOAD;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o     = state_q != ST_IDLE;
  assign scaled_o.x = scaled_q[0];
  assign scaled_o.y = scaled_q[1];
  assign scaled_o.z = scaled_q[2];

endmodule

/* hw/rtl/planar_shadow_vertex_projector.sv */
// top level: configuration registers and the five stage vertex projection pipeline
`timescale 1ns / 1ps

// Flattens Q16.16 vertices onto a ground plane along a light direction.
// Input channel: in_valid_i / in_stall_o carry one vertex word (position and
// last marker); output channel: out_valid_o / out_stall_i carry the projected
// word. A word moves at a clock edge with valid high and stall low.
// Words pass the registered stages to out_valid_o; when nothing stalls, one
// word per cycle is sustained. Each stage advances whenever the stage after it
// is empty or moving, so bubbles close up and a held output word does not stop
// earlier words from filling the empty stages behind it.
// Configuration: cfg_we_i, cfg_idx_i, cfg_wdata_i write one register per
// cycle. Each write restarts the scaled light derivation (light adjustment
// and dot-product passes, then a 61 step serial divider per axis);
// in_stall_o stays high during it. Unknown indexes are ignored.
// Reset clears the pipeline, loads the default z normal and light and the
// matching scaled light of 1.0, so vertices are taken right after reset.
// When the receiver stalls, the output word holds and the pipeline fills.
module planar_shadow_vertex_projector (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [psvp_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [psvp_pkg::CfgDataW-1:0]        cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  psvp_pkg::vtx_in_t                    in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output psvp_pkg::vtx_out_t                   out_data_o
);

  psvp_pkg::cfg_t  cfg_q;
  psvp_pkg::svec_t scaled;
  logic cfg_hit;
  logic busy;

  // configuration registers
  always_comb begin
    case (cfg_idx_i)
      psvp_pkg::CFG_GROUND_X,
      psvp_pkg::CFG_GROUND_Y,
      psvp_pkg::CFG_GROUND_Z,
      psvp_pkg::CFG_LIGHT_X,
      psvp_pkg::CFG_LIGHT_Y,
      psvp_pkg::CFG_LIGHT_Z,
      psvp_pkg::CFG_GROUND_OFFSET: cfg_hit = cfg_we_i;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ground_x      <= '0;
      cfg_q.ground_y      <= '0;
      cfg_q.ground_z      <= psvp_pkg::GROUND_Z_RST;
      cfg_q.light_x       <= '0;
      cfg_q.light_y       <= '0;
      cfg_q.light_z       <= psvp_pkg::LIGHT_Z_RST;
      cfg_q.ground_offset <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        psvp_pkg::CFG_GROUND_X:      cfg_q.ground_x      <= cfg_wdata_i[15:0];
        psvp_pkg::CFG_GROUND_Y:      cfg_q.ground_y      <= cfg_wdata_i[15:0];
        psvp_pkg::CFG_GROUND_Z:      cfg_q.ground_z      <= cfg_wdata_i[15:0];
        psvp_pkg::CFG_LIGHT_X:       cfg_q.light_x       <= cfg_wdata_i[15:0];
        psvp_pkg::CFG_LIGHT_Y:       cfg_q.light_y       <= cfg_wdata_i[15:0];
        psvp_pkg::CFG_LIGHT_Z:       cfg_q.light_z       <= cfg_wdata_i[15:0];
        psvp_pkg::CFG_GROUND_OFFSET: cfg_q.ground_offset <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // scaled light derivation
  psvp_derive u_derive (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cfg_hit),
    .cfg_i    (cfg_q),
    .busy_o   (busy),
    .scaled_o (scaled)
  );

  // pipeline registers
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic adv1, adv2, adv3, adv4, adv5;
  logic in_fire;
  logic last1_q, last2_q, last3_q, last4_q;
  logic signed [31:0] pos1_q [3];
  logic signed [31:0] pos2_q [3];
  logic signed [31:0] pos3_q [3];
  logic signed [31:0] pos4_q [3];
  logic signed [psvp_pkg::PrdW-1:0] prod1_q [3];
  logic signed [psvp_pkg::HW-1:0] h2_q;
  logic [psvp_pkg::HiW-1:0] hi3_q [3];
  logic [psvp_pkg::LoW-1:0] lo3_q [3];
  logic neg3_q [3];
  logic [psvp_pkg::ResW-1:0] res4_q [3];
  logic neg4_q [3];
  psvp_pkg::vtx_out_t out_q;

  logic signed [31:0] pos_in [3];
  logic signed [15:0] gnd [3];
  logic signed [31:0] sl [3];
  logic signed [psvp_pkg::PrdW-1:0] prod [3];
  logic signed [psvp_pkg::HSumW-1:0] off_sh;
  logic signed [psvp_pkg::HSumW-1:0] hsum;
  logic signed [psvp_pkg::HSumW-1:0] h_full;
  logic [31:0] a_mag [3];
  logic [psvp_pkg::HW-1:0] b_mag;
  logic [psvp_pkg::HiW-1:0] hi [3];
  logic [psvp_pkg::LoW-1:0] lo [3];
  logic [psvp_pkg::HiW+psvp_pkg::SplitW:0] rsum [3];
  logic signed [psvp_pkg::CorrW-1:0] corr [3];
  logic signed [31:0] proj [3];

  assign pos_in[0] = in_data_i.pos_x;
  assign pos_in[1] = in_data_i.pos_y;
  assign pos_in[2] = in_data_i.pos_z;
  assign gnd[0]    = cfg_q.ground_x;
  assign gnd[1]    = cfg_q.ground_y;
  assign gnd[2]    = cfg_q.ground_z;
  assign sl[0]     = scaled.x;
  assign sl[1]     = scaled.y;
  assign sl[2]     = scaled.z;

  // stage advance chain
  assign adv5       = !v5_q || !out_stall_i;
  assign adv4       = !v4_q || adv5;
  assign adv3       = !v3_q || adv4;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign in_stall_o = busy || cfg_we_i || !adv1;
  assign in_fire    = in_valid_i && !in_stall_o;

  // stage 1: position times ground normal
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i] = pos_in[i] * gnd[i];
    end
  end

  // stage 2: h = rnd14(pos . ground + offset * 2^14)
  assign off_sh = {{(psvp_pkg::HSumW-46){cfg_q.ground_offset[31]}},
                   cfg_q.ground_offset, 14'd0};
  assign hsum   = prod1_q[0] + prod1_q[1] + prod1_q[2] + off_sh + 50'sd8192;
  assign h_full = hsum >>> 14;

  // stage 3: magnitudes and split multiply
  assign b_mag = h2_q[psvp_pkg::HW-1] ? ~h2_q + 1'b1 : h2_q;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_mag[i] = sl[i][31] ? ~sl[i] + 1'b1 : sl[i];
      hi[i]    = a_mag[i] * b_mag[psvp_pkg::HW-1:psvp_pkg::SplitW];
      lo[i]    = a_mag[i] * b_mag[psvp_pkg::SplitW-1:0];
    end
  end

  // stage 4: rounded correction magnitude, half away from zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rsum[i] = {1'b0, hi3_q[i], {psvp_pkg::SplitW{1'b0}}}
              + {{(psvp_pkg::HiW+psvp_pkg::SplitW+1-psvp_pkg::LoW){1'b0}}, lo3_q[i]}
              + {{(psvp_pkg::HiW+psvp_pkg::SplitW-23){1'b0}}, 1'b1, 23'd0};
    end
  end

  // stage 5: subtract correction and saturate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (neg4_q[i]) begin
        corr[i] = {{(psvp_pkg::CorrW-32){pos4_q[i][31]}}, pos4_q[i]}
                + {{(psvp_pkg::CorrW-psvp_pkg::ResW){1'b0}}, res4_q[i]};
      end else begin
        corr[i] = {{(psvp_pkg::CorrW-32){pos4_q[i][31]}}, pos4_q[i]}
                - {{(psvp_pkg::CorrW-psvp_pkg::ResW){1'b0}}, res4_q[i]};
      end
      if (corr[i][psvp_pkg::CorrW-1] && !(&corr[i][psvp_pkg::CorrW-2:31])) begin
        proj[i] = 32'sh8000_0000;
      end else if (!corr[i][psvp_pkg::CorrW-1] && (|corr[i][psvp_pkg::CorrW-2:31])) begin
        proj[i] = 32'sh7fff_ffff;
      end else begin
        proj[i] = corr[i][31:0];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= in_fire;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
      if (adv4) begin
        v4_q <= v3_q;
      end
      if (adv5) begin
        v5_q <= v4_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (adv1) begin
      last1_q <= in_data_i.last_in;
      for (int i = 0; i < 3; i++) begin
        pos1_q[i]  <= pos_in[i];
        prod1_q[i] <= prod[i];
      end
    end
    if (adv2) begin
      last2_q <= last1_q;
      h2_q    <= h_full[psvp_pkg::HW-1:0];
      for (int i = 0; i < 3; i++) begin
        pos2_q[i] <= pos1_q[i];
      end
    end
    if (adv3) begin
      last3_q <= last2_q;
      for (int i = 0; i < 3; i++) begin
        pos3_q[i] <= pos2_q[i];
        hi3_q[i]  <= hi[i];
        lo3_q[i]  <= lo[i];
        neg3_q[i] <= sl[i][31] ^ h2_q[psvp_pkg::HW-1];
      end
    end
    if (adv4) begin
      last4_q <= last3_q;
      for (int i = 0; i < 3; i++) begin
        pos4_q[i] <= pos3_q[i];
        res4_q[i] <= rsum[i][psvp_pkg::ResW+23:24];
        neg4_q[i] <= neg3_q[i];
      end
    end
    if (adv5) begin
      out_q.proj_x   <= proj[0];
      out_q.proj_y   <= proj[1];
      out_q.proj_z   <= proj[2];
      out_q.last_out <= last4_q;
    end
  end

  assign out_valid_o = v5_q;
  assign out_data_o  = out_q;

endmodule

/* tb/planar_shadow_vertex_projector_tb.sv */
// self-checking testbench: drives vertices under changing plane and light settings
`timescale 1ns / 1ps

module planar_shadow_vertex_projector_tb;

  localparam int     HalfPeriod   = 2;
  localparam int     ResetCycles  = 7;
  localparam int     SettleCycles = 10;
  localparam int     HoldCycles   = 120;
  localparam int     Phases       = 16;
  localparam int     PhaseItems   = 118;
  localparam longint LimitNs      = 2_000_000;

  localparam logic [psvp_pkg::CfgIdxW-1:0] CFG_UNUSED = 3'd7;
  localparam logic [31:0]        S32_MAX    = 32'h7fff_ffff;
  localparam logic [31:0]        S32_MIN    = 32'h8000_0000;
  localparam longint             HalfQ28    = 64'sd1 << 27;

  typedef enum logic [1:0] {ROW_REG, ROW_VTX, ROW_VTX_KNOWN} row_kind_e;

  typedef struct {
    row_kind_e                      kind;
    logic [psvp_pkg::CfgIdxW-1:0]   idx;
    logic [psvp_pkg::CfgDataW-1:0]  wdata;
    psvp_pkg::vtx_in_t              vtx;
    psvp_pkg::vtx_out_t             want;
  } stim_row_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [psvp_pkg::CfgIdxW-1:0]   cfg_idx;
  logic [psvp_pkg::CfgDataW-1:0]  cfg_wdata;
  logic                           in_valid;
  logic                           in_stall;
  psvp_pkg::vtx_in_t              in_data;
  logic                           out_valid;
  logic                           out_stall;
  psvp_pkg::vtx_out_t             out_data;

  // predictor state: register shadow and scaled light in Q8.24
  psvp_pkg::cfg_t      shadow_cfg;
  longint              light_scale [3];
  psvp_pkg::vtx_out_t  pending_proj [$];
  stim_row_t           directed [$];

  int n_vertices = 0;
  int n_directed = 0;
  int n_checked  = 0;
  int n_writes   = 0;
  int n_errors   = 0;
  bit quiet      = 1'b0;
  bit hold_req   = 1'b0;

  planar_shadow_vertex_projector u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #(HalfPeriod) clk = ~clk;

  // round half up after dropping 14 fraction bits
  function automatic longint rnd14(longint x);
    return (x + 64'sd8192) >>> 14;
  endfunction

  function automatic longint clamp32(longint x);
    if (x > longint'($signed(S32_MAX))) return longint'($signed(S32_MAX));
    if (x < longint'($signed(S32_MIN))) return longint'($signed(S32_MIN));
    return x;
  endfunction

  // light over light.ground, with the light tipped toward the normal when too shallow
  function automatic void derive_light_scale();
    longint          g [3];
    longint          lq [3];
    longint          d, k, acc, quot;
    longint unsigned mag, q, du;
    bit              neg;
    g[0]  = shadow_cfg.ground_x;
    g[1]  = shadow_cfg.ground_y;
    g[2]  = shadow_cfg.ground_z;
    lq[0] = shadow_cfg.light_x;
    lq[1] = shadow_cfg.light_y;
    lq[2] = shadow_cfg.light_z;
    d = 0;
    for (int i = 0; i < 3; i++) begin
      d += lq[i] * g[i];
      lq[i] = lq[i] * 16384;
    end
    if (d < HalfQ28) begin
      k = HalfQ28 - d;
      acc = 0;
      for (int i = 0; i < 3; i++) begin
        lq[i] += rnd14(k * g[i]);
        acc += lq[i] * g[i];
      end
      d = rnd14(acc);
    end
    // collapsed divisor becomes one lsb
    if (d <= 0) d = 1;
    du = d;
    for (int i = 0; i < 3; i++) begin
      neg = lq[i] < 0;
      mag = neg ? -lq[i] : lq[i];
      q = ((mag << 24) + (du >> 1)) / du;
      if (q > (64'd1 << 32)) q = 64'd1 << 32;
      quot = neg ? -$signed(q) : $signed(q);
      light_scale[i] = clamp32(quot);
    end
  endfunction

  // s * h / 2^24, rounded half away from zero
  function automatic longint round_mul24(longint s, longint h);
    logic [127:0]    prod;
    longint unsigned a, b;
    bit              neg;
    neg  = (s < 0) != (h < 0);
    a    = (s < 0) ? -s : s;
    b    = (h < 0) ? -h : h;
    prod = ({64'd0, a} * {64'd0, b} + (128'd1 << 23)) >> 24;
    return neg ? -$signed(prod[63:0]) : $signed(prod[63:0]);
  endfunction

  function automatic psvp_pkg::vtx_out_t project_vertex(psvp_pkg::vtx_in_t v);
    longint             p [3];
    longint             g [3];
    longint             acc, h;
    psvp_pkg::vtx_out_t r;
    p[0] = v.pos_x;
    p[1] = v.pos_y;
    p[2] = v.pos_z;
    g[0] = shadow_cfg.ground_x;
    g[1] = shadow_cfg.ground_y;
    g[2] = shadow_cfg.ground_z;
    acc = longint'(shadow_cfg.ground_offset) * 16384;
    for (int i = 0; i < 3; i++) acc += p[i] * g[i];
    h = rnd14(acc);
    r.proj_x   = 32'(clamp32(p[0] - round_mul24(light_scale[0], h)));
    r.proj_y   = 32'(clamp32(p[1] - round_mul24(light_scale[1], h)));
    r.proj_z   = 32'(clamp32(p[2] - round_mul24(light_scale[2], h)));
    r.last_out = v.last_in;
    return r;
  endfunction

  function automatic void store_reg(logic [psvp_pkg::CfgIdxW-1:0] idx,
                                    logic [psvp_pkg::CfgDataW-1:0] data);
    case (idx)
      psvp_pkg::CFG_GROUND_X:      shadow_cfg.ground_x = data[15:0];
      psvp_pkg::CFG_GROUND_Y:      shadow_cfg.ground_y = data[15:0];
      psvp_pkg::CFG_GROUND_Z:      shadow_cfg.ground_z = data[15:0];
      psvp_pkg::CFG_LIGHT_X:       shadow_cfg.light_x = data[15:0];
      psvp_pkg::CFG_LIGHT_Y:       shadow_cfg.light_y = data[15:0];
      psvp_pkg::CFG_LIGHT_Z:       shadow_cfg.light_z = data[15:0];
      psvp_pkg::CFG_GROUND_OFFSET: shadow_cfg.ground_offset = data;
      default:                     return;
    endcase
    derive_light_scale();
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      n_errors++;
    end
  endfunction

  // directed table rows
  function automatic stim_row_t reg_row(logic [psvp_pkg::CfgIdxW-1:0] idx,
                                        logic [psvp_pkg::CfgDataW-1:0] data);
    stim_row_t r;
    r.kind  = ROW_REG;
    r.idx   = idx;
    r.wdata = data;
    r.vtx   = '0;
    r.want  = '0;
    return r;
  endfunction

  function automatic stim_row_t vtx_row(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                        logic last);
    stim_row_t r;
    r.kind  = ROW_VTX;
    r.idx   = '0;
    r.wdata = '0;
    r.vtx   = '{x, y, z, last};
    r.want  = '0;
    return r;
  endfunction

  function automatic stim_row_t known_row(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                          logic last, logic [31:0] ex, logic [31:0] ey,
                                          logic [31:0] ez, logic elast);
    stim_row_t r;
    r      = vtx_row(x, y, z, last);
    r.kind = ROW_VTX_KNOWN;
    r.want = '{ex, ey, ez, elast};
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       return S32_MAX;
          1:       return S32_MIN;
          2:       return '0;
          3:       return '1;
          default: return 32'd1;
        endcase
      end
      1, 2, 3: return $urandom();
      default: return 32'($signed($urandom()) >>> 12);
    endcase
  endfunction

  // one register write, then drop the enable
  task automatic write_reg(logic [psvp_pkg::CfgIdxW-1:0] idx,
                           logic [psvp_pkg::CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    store_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
    n_writes++;
  endtask

  // stop offering words, wait for every projection, let the pipe go quiet
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_proj.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic send_vertex(psvp_pkg::vtx_in_t v, bit known, psvp_pkg::vtx_out_t want);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= v;
    do @(posedge clk); while (in_stall);
    pending_proj.push_back(known ? want : project_vertex(v));
    n_vertices++;
  endtask

  // plane and light for one random phase; first phases take the extremes
  task automatic apply_setting(int p);
    logic [15:0] g [3];
    logic [15:0] lt [3];
    logic [31:0] off;
    int          axis;
    for (int i = 0; i < 3; i++) begin
      g[i]  = $urandom();
      lt[i] = $urandom();
    end
    off = $urandom();
    if (p == 0) begin
      g   = '{default: 16'h7fff};
      lt  = '{default: 16'h7fff};
      off = S32_MAX;
    end else if (p == 1) begin
      g   = '{default: 16'h8000};
      lt  = '{default: 16'h8000};
      off = S32_MIN;
    end else if (p == 2) begin
      g = '{default: 16'h0000};
    end else begin
      case ($urandom_range(0, 2))
        0: begin
          axis    = $urandom_range(0, 2);
          g       = '{default: 16'h0000};
          g[axis] = $urandom_range(0, 1) ? 16'h4000 : 16'hc000;
          for (int i = 0; i < 3; i++) lt[i] = 16'($urandom_range(0, 32768) - 16384);
        end
        1: begin
          for (int i = 0; i < 3; i++) begin
            g[i]  = 16'($urandom_range(0, 32768) - 16384);
            lt[i] = 16'($urandom_range(0, 32768) - 16384);
          end
        end
        default: ;
      endcase
      case ($urandom_range(0, 3))
        0:       off = '0;
        1:       ;
        default: off = 32'($signed($urandom()) >>> 8);
      endcase
    end
    // junk in the upper half of the narrow registers
    write_reg(psvp_pkg::CFG_GROUND_X, {16'($urandom()), g[0]});
    write_reg(psvp_pkg::CFG_GROUND_Y, {16'($urandom()), g[1]});
    write_reg(psvp_pkg::CFG_GROUND_Z, {16'($urandom()), g[2]});
    write_reg(psvp_pkg::CFG_LIGHT_X, {16'($urandom()), lt[0]});
    write_reg(psvp_pkg::CFG_LIGHT_Y, {16'($urandom()), lt[1]});
    write_reg(psvp_pkg::CFG_LIGHT_Z, {16'($urandom()), lt[2]});
    write_reg(psvp_pkg::CFG_GROUND_OFFSET, off);
    if ($urandom_range(0, 1)) write_reg(CFG_UNUSED, $urandom());
  endtask

  function automatic void load_directed();
    // reset plane: z normal, straight light, so x and y pass and z lands on zero
    directed.push_back(known_row('0, '0, '0, 1'b0, '0, '0, '0, 1'b0));
    directed.push_back(known_row(S32_MAX, S32_MIN, S32_MAX, 1'b1, S32_MAX, S32_MIN, '0, 1'b1));
    directed.push_back(known_row(S32_MIN, S32_MAX, S32_MIN, 1'b0, S32_MIN, S32_MAX, '0, 1'b0));
    directed.push_back(known_row(32'h1, '1, '1, 1'b1, 32'h1, '1, '0, 1'b1));
    directed.push_back(known_row(32'h5555_5555, 32'haaaa_aaaa, 32'h0001_0000, 1'b0,
                                 32'h5555_5555, 32'haaaa_aaaa, '0, 1'b0));
    // most negative offset pushes z past the top
    directed.push_back(reg_row(psvp_pkg::CFG_GROUND_OFFSET, S32_MIN));
    directed.push_back(known_row('0, '0, S32_MIN, 1'b1, '0, '0, S32_MAX, 1'b1));
    directed.push_back(known_row('1, 32'h1, S32_MAX, 1'b0, '1, 32'h1, S32_MAX, 1'b0));
    directed.push_back(reg_row(psvp_pkg::CFG_GROUND_OFFSET, S32_MAX));
    directed.push_back(known_row(32'd7, 32'd9, '0, 1'b1, 32'd7, 32'd9, 32'h8000_0001, 1'b1));
    // write to an index with no register behind it
    directed.push_back(reg_row(CFG_UNUSED, 32'hffff_ffff));
    directed.push_back(known_row('0, '0, 32'd12345, 1'b0, '0, '0, 32'h8000_0001, 1'b0));
    directed.push_back(reg_row(psvp_pkg::CFG_GROUND_OFFSET, 32'h0001_0000));
    directed.push_back(known_row(32'h0003_0000, '0, 32'h0002_0000, 1'b1,
                                 32'h0003_0000, '0, 32'hffff_0000, 1'b1));
    // zero normal: divisor collapses, scaled light saturates with the light's sign
    directed.push_back(reg_row(psvp_pkg::CFG_GROUND_Z, 32'habcd_0000));
    directed.push_back(vtx_row('0, '0, '0, 1'b0));
    directed.push_back(vtx_row(32'h1234_5678, 32'hfedc_ba98, 32'h7fff_0000, 1'b1));
    directed.push_back(reg_row(psvp_pkg::CFG_LIGHT_Z, 32'h0000_c000));
    directed.push_back(vtx_row(S32_MAX, S32_MIN, S32_MIN, 1'b1));
    directed.push_back(reg_row(psvp_pkg::CFG_LIGHT_X, 32'h0000_8000));
    directed.push_back(reg_row(psvp_pkg::CFG_LIGHT_Y, 32'hffff_7fff));
    directed.push_back(vtx_row(32'h0000_8000, 32'hffff_8000, 32'h0100_0000, 1'b0));
    // unit normal with a shallow light tipped toward it
    directed.push_back(reg_row(psvp_pkg::CFG_GROUND_Z, 32'h0000_4000));
    directed.push_back(reg_row(psvp_pkg::CFG_LIGHT_X, 32'h0000_2000));
    directed.push_back(reg_row(psvp_pkg::CFG_LIGHT_Y, 32'h0000_0000));
    directed.push_back(reg_row(psvp_pkg::CFG_LIGHT_Z, 32'h0000_1000));
    directed.push_back(vtx_row(32'h0002_0000, 32'hfffe_0000, 32'h0004_0000, 1'b0));
    directed.push_back(vtx_row(S32_MAX, S32_MAX, S32_MAX, 1'b1));
    // tilted normal at the component extremes
    directed.push_back(reg_row(psvp_pkg::CFG_GROUND_X, 32'h0000_7fff));
    directed.push_back(reg_row(psvp_pkg::CFG_GROUND_Y, 32'h0000_8000));
    directed.push_back(reg_row(psvp_pkg::CFG_GROUND_Z, 32'h5a5a_7fff));
    directed.push_back(reg_row(psvp_pkg::CFG_GROUND_OFFSET, S32_MIN));
    directed.push_back(vtx_row(S32_MIN, S32_MAX, S32_MIN, 1'b0));
    directed.push_back(vtx_row(S32_MAX, S32_MIN, '0, 1'b1));
    // light pointing away from the plane
    directed.push_back(reg_row(psvp_pkg::CFG_LIGHT_X, 32'h0000_c000));
    directed.push_back(reg_row(psvp_pkg::CFG_LIGHT_Y, 32'h0000_4000));
    directed.push_back(reg_row(psvp_pkg::CFG_LIGHT_Z, 32'h0000_c000));
    directed.push_back(vtx_row(32'h0010_0000, 32'hfff0_0000, 32'h0000_0001, 1'b0));
  endfunction

  // check each projected word against the oldest prediction
  always @(posedge clk) begin : proj_check
    psvp_pkg::vtx_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_proj.size() == 0) begin
        $display("%0t: projection %h arrived with none pending", $time, out_data);
        n_errors++;
      end else begin
        want = pending_proj.pop_front();
        check_field("proj_x", want.proj_x, out_data.proj_x);
        check_field("proj_y", want.proj_y, out_data.proj_y);
        check_field("proj_z", want.proj_z, out_data.proj_z);
        check_field("last_out", 32'(want.last_out), 32'(out_data.last_out));
        n_checked++;
      end
    end
  end

  // receiver: random stall before each word, one long hold on request
  initial begin : sink_side
    int hold;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        hold     = HoldCycles;
        hold_req = 1'b0;
      end else begin
        hold = quiet ? 0 : $urandom_range(0, 11);
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : watchdog
    #(LimitNs);
    $display("%0t: run stuck with %0d projections pending", $time, pending_proj.size());
    $display("TEST FAILED");
    $finish;
  end

  // sender: directed table, then random phases under fresh settings
  initial begin : stimulus
    stim_row_t          row;
    psvp_pkg::vtx_in_t  v;
    psvp_pkg::vtx_out_t none;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    none      = '0;
    shadow_cfg          = '0;
    shadow_cfg.ground_z = psvp_pkg::GROUND_Z_RST;
    shadow_cfg.light_z  = psvp_pkg::LIGHT_Z_RST;
    derive_light_scale();
    load_directed();
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      row = directed[i];
      if (row.kind == ROW_REG) begin
        wait_idle();
        write_reg(row.idx, row.wdata);
      end else begin
        send_vertex(row.vtx, row.kind == ROW_VTX_KNOWN, row.want);
      end
    end
    n_directed = n_vertices;

    for (int p = 0; p < Phases; p++) begin
      wait_idle();
      apply_setting(p);
      quiet = (p % 4 == 1);
      for (int j = 0; j < PhaseItems; j++) begin
        // long receiver hold while words keep coming
        if (p == 5 && j == 20) hold_req = 1'b1;
        // sender pause until the pipe has emptied
        if (p == 9 && j == 60) wait_idle();
        v.pos_x   = rand_coord();
        v.pos_y   = rand_coord();
        v.pos_z   = rand_coord();
        v.last_in = ($urandom_range(0, 7) == 0);
        send_vertex(v, 1'b0, none);
      end
    end
    wait_idle();

    $display("checked %0d projections from %0d vertices (%0d directed), %0d register writes",
             n_checked, n_vertices, n_directed, n_writes);
    $display("settings spanned reset, both extremes, a zero normal and random planes; %0d errors",
             n_errors);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/psvp_pkg.sv
hw/rtl/psvp_derive.sv
hw/rtl/planar_shadow_vertex_projector.sv
tb/planar_shadow_vertex_projector_tb.sv
